@@ sv/color_match_centroid_core_assert.svh @@
// Assertion macros used by the color match centroid back end (cmc_back).
`ifndef COLOR_MATCH_CENTROID_CORE_ASSERT_SVH
`define COLOR_MATCH_CENTROID_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CMC_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("cmc assertion failed");

// Next-cycle implication, checked outside reset.
`define CMC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("cmc assertion failed");

`endif

@@ sv/cmc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cmc_pkg;

    // Fixed field widths
    localparam int PIX_W      = 8;
    localparam int COUNT_W    = 17;
    localparam int SUM_W      = 25;
    localparam int OFFSET_W   = 9;
    localparam int ROW_OUT_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    // Frame geometry defaults
    localparam int FRAME_COLUMNS_DEF = 320;
    localparam int FRAME_ROWS_DEF    = 240;

    // Frame record queue
    localparam int QUEUE_DEPTH = 2;

    // Divider sequencing
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Saturation limits and channel limits
    localparam logic [COUNT_W-1:0] COUNT_MAX       = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX         = {SUM_W{1'b1}};
    localparam logic [PIX_W-1:0]   CHAN_MAX        = 8'd255;
    localparam logic [PIX_W-1:0]   TOLERANCE_RESET = 8'd5;

    // Register indexes
    typedef enum logic [1:0] {
        REG_TARGET_HUE        = 2'd0,
        REG_TARGET_SATURATION = 2'd1,
        REG_TARGET_VALUE      = 2'd2,
        REG_MATCH_TOLERANCE   = 2'd3
    } cmc_reg_e;

    // Configuration seen by the classifier
    typedef struct packed {
        logic [PIX_W-1:0] target_hue;
        logic [PIX_W-1:0] target_saturation;
        logic [PIX_W-1:0] target_value;
        logic [PIX_W-1:0] match_tolerance;
    } cmc_cfg_t;

    // Per-frame totals handed from front to back
    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum_col;
        logic [SUM_W-1:0]   sum_row;
    } cmc_frame_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIVIDE,
        BACK_FINISH,
        BACK_OUTPUT
    } cmc_back_state_e;

endpackage

`default_nettype wire

@@ sv/cmc_pixel_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cmc_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [cmc_pkg::PIX_W-1:0]   pixel_hue;
    logic [cmc_pkg::PIX_W-1:0]   pixel_saturation;
    logic [cmc_pkg::PIX_W-1:0]   pixel_value;
    logic                        frame_end;

    modport source (
        output valid, pixel_hue, pixel_saturation, pixel_value, frame_end,
        input  ready
    );

    modport sink (
        input  valid, pixel_hue, pixel_saturation, pixel_value, frame_end,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/cmc_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cmc_result_if;
    logic                               valid;
    logic                               ready;
    logic                               found;
    logic signed [cmc_pkg::OFFSET_W-1:0] centroid_x_offset;
    logic [cmc_pkg::ROW_OUT_W-1:0]      centroid_row;
    logic [cmc_pkg::COUNT_W-1:0]        match_count;

    modport source (
        output valid, found, centroid_x_offset, centroid_row, match_count,
        input  ready
    );

    modport sink (
        input  valid, found, centroid_x_offset, centroid_row, match_count,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/color_match_centroid_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Color blob centroid tracker. HSV pixels enter in raster order on the pixel
// channel, one per clock sustained; the front end classifies each pixel and
// keeps saturating match count and column and row sums. The pixel marked
// frame_end closes the frame: its totals go into a two-entry record queue and
// the back end, a 25-step restoring divider that computes both means at once,
// delivers one result word after divide and finish states (a not-found frame
// skips both). The pixel channel stalls only while two finished frames are
// still waiting in the queue. Registers are written over the APB port at byte
// address 4*i: target hue, target saturation, target value, match tolerance.
module color_match_centroid_core #(
    parameter int FRAME_COLUMNS = cmc_pkg::FRAME_COLUMNS_DEF,
    parameter int FRAME_ROWS    = cmc_pkg::FRAME_ROWS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    cmc_pixel_if.sink                         pixel,
    cmc_result_if.source                      result,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [cmc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire [cmc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [cmc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int PW = cmc_pkg::PIX_W;

    logic [PW-1:0]       hue_reg;
    logic [PW-1:0]       sat_reg;
    logic [PW-1:0]       val_reg;
    logic [PW-1:0]       tol_reg;
    logic                cfg_write;
    cmc_pkg::cmc_reg_e   reg_index;
    cmc_pkg::cmc_cfg_t   cfg;
    logic                push_valid;
    cmc_pkg::cmc_frame_t push_data;
    logic                queue_full;
    logic                pop_valid;
    cmc_pkg::cmc_frame_t pop_data;
    logic                pop_ready;

    // Decode the register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = cmc_pkg::cmc_reg_e'(paddr[cmc_pkg::CFG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg <= '0;
            sat_reg <= '0;
            val_reg <= '0;
            tol_reg <= cmc_pkg::TOLERANCE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                cmc_pkg::REG_TARGET_HUE:        hue_reg <= pwdata[PW-1:0];
                cmc_pkg::REG_TARGET_SATURATION: sat_reg <= pwdata[PW-1:0];
                cmc_pkg::REG_TARGET_VALUE:      val_reg <= pwdata[PW-1:0];
                cmc_pkg::REG_MATCH_TOLERANCE:   tol_reg <= pwdata[PW-1:0];
                default:                        hue_reg <= hue_reg;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (reg_index)
            cmc_pkg::REG_TARGET_HUE:        prdata = cmc_pkg::CFG_DATA_W'(hue_reg);
            cmc_pkg::REG_TARGET_SATURATION: prdata = cmc_pkg::CFG_DATA_W'(sat_reg);
            cmc_pkg::REG_TARGET_VALUE:      prdata = cmc_pkg::CFG_DATA_W'(val_reg);
            cmc_pkg::REG_MATCH_TOLERANCE:   prdata = cmc_pkg::CFG_DATA_W'(tol_reg);
            default:                        prdata = '0;
        endcase
    end

    assign cfg.target_hue        = hue_reg;
    assign cfg.target_saturation = sat_reg;
    assign cfg.target_value      = val_reg;
    assign cfg.match_tolerance   = tol_reg;

    cmc_front #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .FRAME_ROWS    (FRAME_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    cmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    cmc_back #(
        .FRAME_COLUMNS (FRAME_COLUMNS),
        .FRAME_ROWS    (FRAME_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ sv/cmc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cmc_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    input  cmc_pkg::cmc_frame_t push_data,
    output logic                full,
    output logic                pop_valid,
    output cmc_pkg::cmc_frame_t pop_data,
    input  wire                 pop_ready
);

    localparam int PTR_W = (cmc_pkg::QUEUE_DEPTH > 1) ? $clog2(cmc_pkg::QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(cmc_pkg::QUEUE_DEPTH - 1);

    cmc_pkg::cmc_frame_t entry_reg [cmc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W:0]      fill_reg;
    logic                do_push;
    logic                do_pop;

    // Flag fill state
    assign full      = (fill_reg == (PTR_W + 1)'(cmc_pkg::QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/cmc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cmc_front #(
    parameter int FRAME_COLUMNS = cmc_pkg::FRAME_COLUMNS_DEF,
    parameter int FRAME_ROWS    = cmc_pkg::FRAME_ROWS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    cmc_pixel_if.sink           pixel,
    input  cmc_pkg::cmc_cfg_t   cfg,
    output logic                push_valid,
    output cmc_pkg::cmc_frame_t push_data,
    input  wire                 queue_full
);

    localparam int COL_W = $clog2(FRAME_COLUMNS);
    localparam int ROW_W = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(FRAME_COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FRAME_ROWS - 1);
    localparam int CW = cmc_pkg::COUNT_W;
    localparam int SW = cmc_pkg::SUM_W;
    localparam int PW = cmc_pkg::PIX_W;

    logic [COL_W-1:0] col_reg,     col_next;
    logic [ROW_W-1:0] row_reg,     row_next;
    logic [CW-1:0]    count_reg,   count_next;
    logic [SW-1:0]    sum_col_reg, sum_col_next;
    logic [SW-1:0]    sum_row_reg, sum_row_next;

    logic          fire;
    logic          enabled;
    logic          hue_ok;
    logic          sat_ok;
    logic          val_ok;
    logic          match;
    logic [PW:0]   sat_hi_raw;
    logic [PW-1:0] sat_hi;
    logic [PW-1:0] sat_lo;
    logic [PW:0]   val_hi;
    logic [PW:0]   val_plus_tol;
    logic [CW-1:0] count_upd;
    logic [SW:0]   sum_col_wide;
    logic [SW:0]   sum_row_wide;
    logic [SW-1:0] sum_col_upd;
    logic [SW-1:0] sum_row_upd;

    // Accept pixels unless the record queue is full
    assign pixel.ready = !queue_full;
    assign fire        = pixel.valid && !queue_full;

    // Classify the pixel against the target
    assign enabled = (cfg.target_hue != '0) || (cfg.target_saturation != '0)
                  || (cfg.target_value != '0);
    assign hue_ok  = (pixel.pixel_hue == cfg.target_hue);

    assign sat_hi_raw = {1'b0, cfg.target_saturation} + {1'b0, cfg.match_tolerance};
    assign sat_hi     = (sat_hi_raw > {1'b0, cmc_pkg::CHAN_MAX}) ? cmc_pkg::CHAN_MAX
                                                                  : sat_hi_raw[PW-1:0];
    assign sat_lo     = (cfg.target_saturation < cfg.match_tolerance) ? '0
                      : cfg.target_saturation - cfg.match_tolerance;
    assign sat_ok     = (pixel.pixel_saturation >= sat_lo) && (pixel.pixel_saturation <= sat_hi);

    // Strict value band: v > tv - tol is v + tol > tv
    assign val_hi       = {1'b0, cfg.target_value} + {1'b0, cfg.match_tolerance};
    assign val_plus_tol = {1'b0, pixel.pixel_value} + {1'b0, cfg.match_tolerance};
    assign val_ok       = (val_plus_tol > {1'b0, cfg.target_value})
                       && ({1'b0, pixel.pixel_value} < val_hi);

    assign match = enabled && hue_ok && sat_ok && val_ok;

    // Saturating accumulation of the current pixel
    assign sum_col_wide = {1'b0, sum_col_reg} + (SW + 1)'(col_reg);
    assign sum_row_wide = {1'b0, sum_row_reg} + (SW + 1)'(row_reg);

    always_comb
    begin
        count_upd   = count_reg;
        sum_col_upd = sum_col_reg;
        sum_row_upd = sum_row_reg;
        if (match)
        begin
            count_upd   = (count_reg == cmc_pkg::COUNT_MAX) ? count_reg : count_reg + 1'b1;
            sum_col_upd = sum_col_wide[SW] ? cmc_pkg::SUM_MAX : sum_col_wide[SW-1:0];
            sum_row_upd = sum_row_wide[SW] ? cmc_pkg::SUM_MAX : sum_row_wide[SW-1:0];
        end
    end

    // Hand the frame totals to the back end on the last pixel
    assign push_valid        = fire && pixel.frame_end;
    assign push_data.found   = enabled && (count_upd != '0);
    assign push_data.count   = count_upd;
    assign push_data.sum_col = sum_col_upd;
    assign push_data.sum_row = sum_row_upd;

    // Advance raster position, clear at frame end
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        count_next   = count_reg;
        sum_col_next = sum_col_reg;
        sum_row_next = sum_row_reg;
        if (fire)
        begin
            if (pixel.frame_end)
            begin
                col_next     = '0;
                row_next     = '0;
                count_next   = '0;
                sum_col_next = '0;
                sum_row_next = '0;
            end
            else
            begin
                count_next   = count_upd;
                sum_col_next = sum_col_upd;
                sum_row_next = sum_row_upd;
                if (col_reg == LAST_COL)
                begin
                    col_next = '0;
                    row_next = (row_reg == LAST_ROW) ? '0 : row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            count_reg   <= '0;
            sum_col_reg <= '0;
            sum_row_reg <= '0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            count_reg   <= count_next;
            sum_col_reg <= sum_col_next;
            sum_row_reg <= sum_row_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/cmc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "color_match_centroid_core_assert.svh"

module cmc_back #(
    parameter int FRAME_COLUMNS = cmc_pkg::FRAME_COLUMNS_DEF,
    parameter int FRAME_ROWS    = cmc_pkg::FRAME_ROWS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 pop_valid,
    input  cmc_pkg::cmc_frame_t pop_data,
    output logic                pop_ready,
    cmc_result_if.source        result
);

    localparam int CW = cmc_pkg::COUNT_W;
    localparam int SW = cmc_pkg::SUM_W;
    localparam logic [cmc_pkg::STEP_W-1:0] LAST_STEP = cmc_pkg::STEP_W'(cmc_pkg::DIV_STEPS - 1);

    cmc_pkg::cmc_back_state_e state_reg, state_next;

    logic [cmc_pkg::STEP_W-1:0] step_reg;
    logic [CW-1:0]              divisor_reg;
    logic [CW-1:0]              rem_x_reg;
    logic [CW-1:0]              rem_y_reg;
    logic [SW-1:0]              quo_x_reg;
    logic [SW-1:0]              quo_y_reg;

    logic                           res_found_reg;
    logic [cmc_pkg::OFFSET_W-1:0]   res_off_reg;
    logic [cmc_pkg::ROW_OUT_W-1:0]  res_row_reg;
    logic [CW-1:0]                  res_count_reg;

    logic [CW:0]   trial_x;
    logic [CW:0]   trial_y;
    logic [CW:0]   diff_x;
    logic [CW:0]   diff_y;
    logic          ge_x;
    logic          ge_y;
    logic [31:0]   mean_x;
    logic [31:0]   mean_y;
    logic [31:0]   offset_w;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cmc_pkg::BACK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = pop_data.found ? cmc_pkg::BACK_DIVIDE : cmc_pkg::BACK_OUTPUT;
                end
            end
            cmc_pkg::BACK_DIVIDE:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = cmc_pkg::BACK_FINISH;
                end
            end
            cmc_pkg::BACK_FINISH:
            begin
                state_next = cmc_pkg::BACK_OUTPUT;
            end
            cmc_pkg::BACK_OUTPUT:
            begin
                if (result.ready)
                begin
                    state_next = cmc_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = cmc_pkg::BACK_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        pop_ready    = 1'b0;
        result.valid = 1'b0;
        unique case (state_reg)
            cmc_pkg::BACK_IDLE:   pop_ready    = 1'b1;
            cmc_pkg::BACK_OUTPUT: result.valid = 1'b1;
            default:
            begin
                pop_ready    = 1'b0;
                result.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cmc_pkg::BACK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // One restoring step per cycle for both means
    assign trial_x = {rem_x_reg, quo_x_reg[SW-1]};
    assign trial_y = {rem_y_reg, quo_y_reg[SW-1]};
    assign diff_x  = trial_x - {1'b0, divisor_reg};
    assign diff_y  = trial_y - {1'b0, divisor_reg};
    assign ge_x    = (trial_x >= {1'b0, divisor_reg});
    assign ge_y    = (trial_y >= {1'b0, divisor_reg});

    // Clamp the means and center the column
    always_comb
    begin
        mean_x = 32'(quo_x_reg);
        mean_y = 32'(quo_y_reg);
        if (mean_x > 32'(FRAME_COLUMNS - 1))
        begin
            mean_x = 32'(FRAME_COLUMNS - 1);
        end
        if (mean_y > 32'(FRAME_ROWS - 1))
        begin
            mean_y = 32'(FRAME_ROWS - 1);
        end
        offset_w = mean_x - 32'(FRAME_COLUMNS / 2);
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            cmc_pkg::BACK_IDLE:
            begin
                step_reg      <= '0;
                divisor_reg   <= pop_data.count;
                rem_x_reg     <= '0;
                rem_y_reg     <= '0;
                quo_x_reg     <= pop_data.sum_col;
                quo_y_reg     <= pop_data.sum_row;
                res_found_reg <= pop_data.found;
                res_off_reg   <= '0;
                res_row_reg   <= '0;
                res_count_reg <= pop_data.found ? pop_data.count : '0;
            end
            cmc_pkg::BACK_DIVIDE:
            begin
                step_reg  <= step_reg + 1'b1;
                rem_x_reg <= ge_x ? diff_x[CW-1:0] : trial_x[CW-1:0];
                rem_y_reg <= ge_y ? diff_y[CW-1:0] : trial_y[CW-1:0];
                quo_x_reg <= {quo_x_reg[SW-2:0], ge_x};
                quo_y_reg <= {quo_y_reg[SW-2:0], ge_y};
            end
            cmc_pkg::BACK_FINISH:
            begin
                res_off_reg <= offset_w[cmc_pkg::OFFSET_W-1:0];
                res_row_reg <= mean_y[cmc_pkg::ROW_OUT_W-1:0];
            end
            default:
            begin
                res_found_reg <= res_found_reg;
            end
        endcase
    end

    // Drive the result word
    assign result.found             = res_found_reg;
    assign result.centroid_x_offset = res_off_reg;
    assign result.centroid_row      = res_row_reg;
    assign result.match_count       = res_count_reg;

    `CMC_ASSERT_IMPLY(a_not_found_zero, clk, rst_n, result.valid && !result.found, (result.centroid_x_offset == '0) && (result.centroid_row == '0) && (result.match_count == '0))
    `CMC_ASSERT_IMPLY(a_found_has_count, clk, rst_n, result.valid && result.found, result.match_count != '0)
    `CMC_ASSERT_NEXT(a_pop_leaves_idle, clk, rst_n, pop_valid && pop_ready, state_reg != cmc_pkg::BACK_IDLE)
    `CMC_ASSERT_NEXT(a_divide_ends, clk, rst_n, (state_reg == cmc_pkg::BACK_DIVIDE) && (step_reg == LAST_STEP), state_reg == cmc_pkg::BACK_FINISH)

endmodule

`default_nettype wire
